// ===== rtl/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg: shared constants for the slab object allocator
// Field widths, operation codes, status codes, list ids and register indexes.
// ----------------------------------------------------------------------------
package soa_pkg;

   // payload field widths
   localparam int OPCODE_W = 2;
   localparam int SLABID_W = 4;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 19;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DESTROY = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;   // no operation

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFRAME = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;

   // slab list ids
   localparam logic [1:0] LIST_FULL = 2'd0;
   localparam logic [1:0] LIST_PART = 2'd1;
   localparam logic [1:0] LIST_FREE = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_OBJECTS = 3'd0;
   localparam logic [2:0] REG_ORDER   = 3'd1;
   localparam logic [2:0] REG_BUFFER  = 3'd2;
   localparam logic [2:0] REG_ALIGN   = 3'd3;
   localparam logic [2:0] REG_COLOR   = 3'd4;

endpackage

// ===== rtl/soa_req_if.sv =====
// ----------------------------------------------------------------------------
// soa_req_if: request channel
// Valid/ready channel carrying one allocator request item.
// ----------------------------------------------------------------------------
interface soa_req_if;
   logic                           valid;
   logic                           ready;
   logic [soa_pkg::OPCODE_W-1:0]   opcode;
   logic [soa_pkg::SLABID_W-1:0]   slab_id;
   logic [soa_pkg::SLOT_W-1:0]     object_slot;

   modport source (output valid, opcode, slab_id, object_slot, input ready);
   modport sink   (input valid, opcode, slab_id, object_slot, output ready);
endinterface

// ===== rtl/soa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// soa_rsp_if: response channel
// Valid/ready channel carrying one allocator result item.
// ----------------------------------------------------------------------------
interface soa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [soa_pkg::STATUS_W-1:0]   status;
   logic [soa_pkg::SLABID_W-1:0]   given_slab;
   logic [soa_pkg::SLOT_W-1:0]     given_slot;
   logic [soa_pkg::OFFSET_W-1:0]   object_offset;

   modport source (output valid, status, given_slab, given_slot, object_offset,
                   input ready);
   modport sink   (input valid, status, given_slab, given_slot, object_offset,
                   output ready);
endinterface

// ===== rtl/soa_ram.sv =====
// ----------------------------------------------------------------------------
// soa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module soa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/slab_object_allocator.sv =====
// ----------------------------------------------------------------------------
// slab_object_allocator: slab allocator for one object cache
// Requests arrive on req (allocate, free object, destroy cache); each gives
// exactly one result item on rsp. Geometry is set through the APB port.
//
// Usage:
//  - One item is worked on at a time; req.ready is high only while idle.
//    The result sits in an output register, so a new item is taken while
//    the previous result still waits on a stalled rsp.ready.
//  - A free of a slab whose used count is zero is ignored. Allocating
//    into a fresh slab first builds the slab's free list, one link per
//    object.
//  - Items do not overlap: the next item is accepted once the previous
//    result has entered the output register.
//  - The sequencer does one read-modify-write per slab record through the
//    record RAM (one read, one write port); list moves of a slab touch up
//    to three other records.
//  - Reset empties all lists and the frame pool; no memory is cleared, so
//    the block takes items in the first cycle after reset.
//  - Configuration is to be written through the APB port only while the
//    block is idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
   parameter int SLAB_FRAMES = 16,
   parameter int MAX_SLOTS   = 64,
   parameter int PAGE_BYTES  = 4096,
   parameter int MAX_ORDER   = 3
) (
   input  logic         clock,
   input  logic         reset,
   soa_req_if.sink      req,
   soa_rsp_if.source    rsp,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   // widths derived from the pool geometry
   localparam int SW  = $clog2(SLAB_FRAMES + 1);
   localparam int SIW = SLAB_FRAMES > 1 ? $clog2(SLAB_FRAMES) : 1;
   localparam int KW  = $clog2(MAX_SLOTS + 1);
   localparam int KIW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
   localparam logic [SW-1:0] NO_SLAB = SW'(SLAB_FRAMES);
   localparam logic [KW-1:0] NO_SLOT = KW'(MAX_SLOTS);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_REC   = 4'd1;
   localparam logic [3:0] S_INIT  = 4'd2;
   localparam logic [3:0] S_TAKE  = 4'd3;
   localparam logic [3:0] S_TAKEW = 4'd4;
   localparam logic [3:0] S_MVP   = 4'd5;
   localparam logic [3:0] S_MVPW  = 4'd6;
   localparam logic [3:0] S_MVN   = 4'd7;
   localparam logic [3:0] S_MVNW  = 4'd8;
   localparam logic [3:0] S_ADD   = 4'd9;
   localparam logic [3:0] S_ADDW  = 4'd10;
   localparam logic [3:0] S_WB    = 4'd11;
   localparam logic [3:0] S_OFF1  = 4'd12;
   localparam logic [3:0] S_OFF2  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   // item kinds
   localparam logic [1:0] K_PART  = 2'd0;
   localparam logic [1:0] K_FREEL = 2'd1;
   localparam logic [1:0] K_NEW   = 2'd2;
   localparam logic [1:0] K_FREE  = 2'd3;

   typedef struct packed {
      logic [14:0]   color;
      logic [KW-1:0] used;
      logic [KW-1:0] head;
      logic [SW-1:0] prv;
      logic [SW-1:0] nxt;
      logic [1:0]    on;
   } rec_type;

   // configuration registers
   logic [6:0]  cfg_objects_ff;
   logic [1:0]  cfg_order_ff;
   logic [15:0] cfg_buffer_ff;
   logic [12:0] cfg_align_ff;
   logic [14:0] cfg_color_ff;

   // control and working registers
   logic [3:0]     state_ff, state_in;
   logic [3:0]     after_ff, after_in;
   logic [1:0]     kind_ff, kind_in;
   logic [1:0]     dest_ff, dest_in;
   logic           front_ff, front_in;
   logic [SIW-1:0] s_ff, s_in;
   logic [KIW-1:0] slot_ff, slot_in;
   logic [KIW-1:0] i_ff, i_in;
   rec_type        cur_ff, cur_in;
   logic [SW-1:0]  made_ff, made_in;
   logic [14:0]    color_ff, color_in;
   logic [SW-1:0]  head_ff [0:2];
   logic [SW-1:0]  head_in [0:2];
   logic [SW-1:0]  tail_ff [0:2];
   logic [SW-1:0]  tail_in [0:2];
   logic [31:0]    mul_a_ff, mul_a_in;
   logic [31:0]    mul_b_ff, mul_b_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [18:0]    res_off_ff, res_off_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [3:0]     rsp_slab_ff, rsp_slab_in;
   logic [5:0]     rsp_slot_ff, rsp_slot_in;
   logic [18:0]    rsp_off_ff, rsp_off_in;

   // memory ports
   logic                 rec_we;
   logic [SIW-1:0]       rec_waddr, rec_raddr;
   rec_type              rec_wdata, rec_rdata;
   logic                 lnk_we;
   logic [SIW+KIW-1:0]   lnk_waddr, lnk_raddr;
   logic [KW-1:0]        lnk_wdata, lnk_rdata;

   // effective geometry
   logic [KW-1:0] cap;
   logic [3:0]    eff_order;
   logic [15:0]   color_sum;
   logic [KW-1:0] used_m1, used_p1;

   assign cap = (cfg_objects_ff == 7'd0) ? KW'(1) :
                (int'(cfg_objects_ff) > MAX_SLOTS) ? NO_SLOT : KW'(cfg_objects_ff);
   assign eff_order = (int'(cfg_order_ff) > MAX_ORDER) ? 4'(MAX_ORDER) : 4'(cfg_order_ff);
   assign color_sum = {1'b0, color_ff} + {3'b0, cfg_align_ff};
   assign used_m1   = rec_rdata.used - KW'(1);
   assign used_p1   = cur_ff.used + KW'(1);

   // slab records and per-slot free-list links
   soa_ram #(.WIDTH($bits(rec_type)), .DEPTH(SLAB_FRAMES)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   soa_ram #(.WIDTH(KW), .DEPTH(SLAB_FRAMES << KIW)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_addr (lnk_raddr),
      .rd_data (lnk_rdata)
   );

   // APB configuration port
   assign pready = 1'b1;
   always_comb begin
      case (paddr[4:2])
         soa_pkg::REG_OBJECTS: prdata = {25'd0, cfg_objects_ff};
         soa_pkg::REG_ORDER:   prdata = {30'd0, cfg_order_ff};
         soa_pkg::REG_BUFFER:  prdata = {16'd0, cfg_buffer_ff};
         soa_pkg::REG_ALIGN:   prdata = {19'd0, cfg_align_ff};
         soa_pkg::REG_COLOR:   prdata = {17'd0, cfg_color_ff};
         default:              prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_objects_ff <= 7'd1;
         cfg_order_ff   <= 2'd0;
         cfg_buffer_ff  <= 16'd8;
         cfg_align_ff   <= 13'd8;
         cfg_color_ff   <= 15'd0;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[4:2])
            soa_pkg::REG_OBJECTS: cfg_objects_ff <= pwdata[6:0];
            soa_pkg::REG_ORDER:   cfg_order_ff   <= pwdata[1:0];
            soa_pkg::REG_BUFFER:  cfg_buffer_ff  <= pwdata[15:0];
            soa_pkg::REG_ALIGN:   cfg_align_ff   <= pwdata[12:0];
            soa_pkg::REG_COLOR:   cfg_color_ff   <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      after_in      = after_ff;
      kind_in       = kind_ff;
      dest_in       = dest_ff;
      front_in      = front_ff;
      s_in          = s_ff;
      slot_in       = slot_ff;
      i_in          = i_ff;
      cur_in        = cur_ff;
      made_in       = made_ff;
      color_in      = color_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slab_in   = rsp_slab_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_off_in    = rsp_off_ff;
      rec_we        = 1'b0;
      rec_waddr     = s_ff;
      rec_wdata     = cur_ff;
      rec_raddr     = s_ff;
      lnk_we        = 1'b0;
      lnk_waddr     = {s_ff, slot_ff};
      lnk_wdata     = NO_SLOT;
      lnk_raddr     = {s_ff, cur_ff.head[KIW-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               res_status_in = soa_pkg::ST_OK;
               res_off_in    = '0;
               slot_in       = '0;
               s_in          = '0;
               state_in      = S_DONE;
               case (req.opcode)
                  soa_pkg::OP_ALLOC: begin
                     if (head_ff[soa_pkg::LIST_PART] != NO_SLAB) begin
                        s_in      = SIW'(head_ff[soa_pkg::LIST_PART]);
                        rec_raddr = s_in;
                        kind_in   = K_PART;
                        state_in  = S_REC;
                     end else if (head_ff[soa_pkg::LIST_FREE] != NO_SLAB) begin
                        s_in      = SIW'(head_ff[soa_pkg::LIST_FREE]);
                        rec_raddr = s_in;
                        kind_in   = K_FREEL;
                        state_in  = S_REC;
                     end else if (int'(made_ff) >= SLAB_FRAMES) begin
                        res_status_in = soa_pkg::ST_NOFRAME;
                     end else begin
                        s_in         = SIW'(made_ff);
                        kind_in      = K_NEW;
                        cur_in.color = color_ff;
                        cur_in.used  = '0;
                        cur_in.head  = '0;
                        i_in         = '0;
                        state_in     = S_INIT;
                     end
                  end
                  soa_pkg::OP_FREE: begin
                     if (int'(req.slab_id) < int'(made_ff) &&
                         int'(req.slab_id) < SLAB_FRAMES &&
                         int'(req.object_slot) < int'(cap)) begin
                        s_in      = SIW'(req.slab_id);
                        slot_in   = KIW'(req.object_slot);
                        rec_raddr = s_in;
                        kind_in   = K_FREE;
                        state_in  = S_REC;
                     end
                  end
                  soa_pkg::OP_DESTROY: begin
                     if (head_ff[soa_pkg::LIST_FULL] != NO_SLAB ||
                         head_ff[soa_pkg::LIST_PART] != NO_SLAB) begin
                        res_status_in = soa_pkg::ST_BUSY;
                     end else begin
                        made_in  = '0;
                        color_in = '0;
                        for (int l = 0; l < 3; l++) begin
                           head_in[l] = NO_SLAB;
                           tail_in[l] = NO_SLAB;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // slab record is in; check it and plan the update
         S_REC: begin
            cur_in = rec_rdata;
            if (kind_ff == K_FREE) begin
               if (rec_rdata.used == '0) begin
                  state_in = S_DONE;
               end else begin
                  lnk_we      = 1'b1;
                  lnk_wdata   = rec_rdata.head;
                  cur_in.head = KW'(slot_ff);
                  cur_in.used = used_m1;
                  front_in    = 1'b1;
                  after_in    = S_WB;
                  if (used_m1 == '0) begin
                     dest_in  = soa_pkg::LIST_FREE;
                     state_in = S_MVP;
                  end else if (used_m1 == cap - KW'(1)) begin
                     dest_in  = soa_pkg::LIST_PART;
                     state_in = S_MVP;
                  end else begin
                     state_in = S_WB;
                  end
               end
            end else if (rec_rdata.head >= NO_SLOT) begin
               res_status_in = soa_pkg::ST_NOFRAME;
               state_in      = S_DONE;
            end else if (kind_ff == K_FREEL) begin
               dest_in  = soa_pkg::LIST_PART;
               front_in = 1'b0;
               after_in = S_TAKE;
               state_in = S_MVP;
            end else begin
               state_in = S_TAKE;
            end
         end

         // build the free list of a fresh slab, one link per cycle
         S_INIT: begin
            lnk_we    = 1'b1;
            lnk_waddr = {s_ff, i_ff};
            lnk_wdata = (KW'(i_ff) + KW'(1) < cap) ? KW'(i_ff) + KW'(1) : NO_SLOT;
            i_in      = i_ff + KIW'(1);
            if (KW'(i_ff) + KW'(1) >= cap) begin
               made_in  = made_ff + SW'(1);
               color_in = (color_sum > {1'b0, cfg_color_ff}) ? 15'd0 : color_sum[14:0];
               dest_in  = soa_pkg::LIST_PART;
               front_in = 1'b0;
               after_in = S_TAKE;
               state_in = S_ADD;
            end
         end

         S_TAKE: begin
            state_in = S_TAKEW;
         end

         // pop the head slot
         S_TAKEW: begin
            slot_in     = cur_ff.head[KIW-1:0];
            cur_in.head = lnk_rdata;
            cur_in.used = used_p1;
            if (used_p1 >= cap) begin
               dest_in  = soa_pkg::LIST_FULL;
               front_in = 1'b0;
               after_in = S_WB;
               state_in = S_MVP;
            end else begin
               state_in = S_WB;
            end
         end

         // unlink: patch the previous slab
         S_MVP: begin
            if (cur_ff.prv == NO_SLAB) begin
               head_in[cur_ff.on] = cur_ff.nxt;
               state_in = S_MVN;
            end else begin
               rec_raddr = SIW'(cur_ff.prv);
               state_in  = S_MVPW;
            end
         end

         S_MVPW: begin
            rec_we        = 1'b1;
            rec_waddr     = SIW'(cur_ff.prv);
            rec_wdata     = rec_rdata;
            rec_wdata.nxt = cur_ff.nxt;
            state_in      = S_MVN;
         end

         // unlink: patch the next slab
         S_MVN: begin
            if (cur_ff.nxt == NO_SLAB) begin
               tail_in[cur_ff.on] = cur_ff.prv;
               state_in = S_ADD;
            end else begin
               rec_raddr = SIW'(cur_ff.nxt);
               state_in  = S_MVNW;
            end
         end

         S_MVNW: begin
            rec_we        = 1'b1;
            rec_waddr     = SIW'(cur_ff.nxt);
            rec_wdata     = rec_rdata;
            rec_wdata.prv = cur_ff.prv;
            state_in      = S_ADD;
         end

         // link at the front or back of the destination list
         S_ADD: begin
            cur_in.on = dest_ff;
            state_in  = after_ff;
            if (front_ff) begin
               cur_in.prv = NO_SLAB;
               cur_in.nxt = head_ff[dest_ff];
               head_in[dest_ff] = SW'(s_ff);
               if (head_ff[dest_ff] == NO_SLAB) begin
                  tail_in[dest_ff] = SW'(s_ff);
               end else begin
                  rec_raddr = SIW'(head_ff[dest_ff]);
                  state_in  = S_ADDW;
               end
            end else begin
               cur_in.nxt = NO_SLAB;
               cur_in.prv = tail_ff[dest_ff];
               tail_in[dest_ff] = SW'(s_ff);
               if (tail_ff[dest_ff] == NO_SLAB) begin
                  head_in[dest_ff] = SW'(s_ff);
               end else begin
                  rec_raddr = SIW'(tail_ff[dest_ff]);
                  state_in  = S_ADDW;
               end
            end
         end

         S_ADDW: begin
            rec_we    = 1'b1;
            rec_wdata = rec_rdata;
            if (front_ff) begin
               rec_waddr     = SIW'(cur_ff.nxt);
               rec_wdata.prv = SW'(s_ff);
            end else begin
               rec_waddr     = SIW'(cur_ff.prv);
               rec_wdata.nxt = SW'(s_ff);
            end
            state_in = after_ff;
         end

         // write the slab record back
         S_WB: begin
            rec_we   = 1'b1;
            state_in = (kind_ff == K_FREE) ? S_DONE : S_OFF1;
         end

         S_OFF1: begin
            mul_a_in = 32'(s_ff) * 32'(PAGE_BYTES);
            mul_b_in = 32'(slot_ff) * 32'(cfg_buffer_ff);
            state_in = S_OFF2;
         end

         S_OFF2: begin
            res_off_in = 19'((mul_a_ff << eff_order) + 32'(cur_ff.color) + mul_b_ff);
            state_in   = S_DONE;
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slab_in   = 4'(s_ff);
               rsp_slot_in   = 6'(slot_ff);
               rsp_off_in    = res_off_ff;
               if (res_status_ff != soa_pkg::ST_OK ||
                   !(kind_ff == K_PART || kind_ff == K_FREEL || kind_ff == K_NEW)) begin
                  rsp_slab_in = '0;
                  rsp_slot_in = '0;
                  rsp_off_in  = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // kind is forced to K_FREE for non-alloc items so DONE zeroes the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         made_ff      <= '0;
         color_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= K_FREE;
         for (int l = 0; l < 3; l++) begin
            head_ff[l] <= NO_SLAB;
            tail_ff[l] <= NO_SLAB;
         end
      end else begin
         state_ff     <= state_in;
         made_ff      <= made_in;
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= (state_ff == S_IDLE && req.valid && req.opcode != soa_pkg::OP_ALLOC)
                         ? K_FREE : kind_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      after_ff      <= after_in;
      dest_ff       <= dest_in;
      front_ff      <= front_in;
      s_ff          <= s_in;
      slot_ff       <= slot_in;
      i_ff          <= i_in;
      cur_ff        <= cur_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slab_ff   <= rsp_slab_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.given_slab    = rsp_slab_ff;
   assign rsp.given_slot    = rsp_slot_ff;
   assign rsp.object_offset = rsp_off_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after accepting an item");

   a_made_bound: assert property (@(posedge clock) disable iff (reset)
      int'(made_ff) <= SLAB_FRAMES)
      else $error("more slabs made than frames");

   a_fail_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != soa_pkg::ST_OK) |->
      (rsp_slab_ff == '0 && rsp_slot_ff == '0 && rsp_off_ff == '0))
      else $error("failed result carries an object");

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
      ((head_ff[0] == NO_SLAB) == (tail_ff[0] == NO_SLAB) &&
       (head_ff[1] == NO_SLAB) == (tail_ff[1] == NO_SLAB) &&
       (head_ff[2] == NO_SLAB) == (tail_ff[2] == NO_SLAB)))
      else $error("list head and tail disagree on empty");
`endif

endmodule
